// ===== rtl/core/sohrc_pkg.sv =====
`default_nettype none
package sohrc_pkg;

    // Widths fixed by the field definitions
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int OFFSET_W        = 24;
    localparam int WEIGHT_W        = 25;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 25;

    // Weight saturation limits
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd6;

    // Configuration reset values
    localparam logic [7:0]                 RST_DEBOUNCE = 8'd30;
    localparam logic [7:0]                 RST_PERIOD   = 8'd3;
    localparam logic [15:0]                RST_STEPS    = 16'd1024;
    localparam logic [15:0]                RST_HOLD     = 16'd3000;
    localparam logic signed [WEIGHT_W-1:0] RST_TRIGGER  = 25'sd500;
    localparam logic signed [WEIGHT_W-1:0] RST_REARM    = 25'sd450;
    localparam logic signed [OFFSET_W-1:0] RST_OFFSET   = 24'sd0;

    // Motor sequencer state
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_OUT  = 2'd1,
        MODE_HOLD = 2'd2,
        MODE_HOME = 2'd3
    } t_mode;

    // Configuration register set
    typedef struct packed {
        logic [7:0]                 debounce_ticks;
        logic [7:0]                 step_period;
        logic [15:0]                steps_per_move;
        logic [15:0]                hold_ticks;
        logic signed [WEIGHT_W-1:0] trigger_level;
        logic signed [WEIGHT_W-1:0] rearm_level;
        logic signed [OFFSET_W-1:0] weight_offset;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/core/sohrc_in_if.sv =====
`default_nettype none
interface sohrc_in_if #(
    parameter int SAMPLE_BITS = sohrc_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   button_raw;
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] sample_counts;

    modport source (output valid, output button_raw, output sample_valid,
                    output sample_counts, input ready);
    modport sink   (input valid, input button_raw, input sample_valid,
                    input sample_counts, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sohrc_out_if.sv =====
`default_nettype none
interface sohrc_out_if;
    import sohrc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [3:0]                 coil_drive;
    logic [1:0]                 motor_state;
    logic [7:0]                 cycle_total;
    logic signed [WEIGHT_W-1:0] weight_now;
    logic                       button_stable;
    logic                       weight_armed;

    modport source (output valid, output coil_drive, output motor_state,
                    output cycle_total, output weight_now, output button_stable,
                    output weight_armed, input ready);
    modport sink   (input valid, input coil_drive, input motor_state,
                    input cycle_total, input weight_now, input button_stable,
                    input weight_armed, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sohrc_cfg_if.sv =====
`default_nettype none
interface sohrc_cfg_if;
    import sohrc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sohrc_cfg_regs.sv =====
`default_nettype none
module sohrc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [sohrc_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [sohrc_pkg::CFG_DATA_W-1:0] i_wr_data,
    output sohrc_pkg::t_cfg                       o_cfg
);
    import sohrc_pkg::*;

    t_cfg r_cfg;

    // Register file, one write per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= RST_DEBOUNCE;
            r_cfg.step_period    <= RST_PERIOD;
            r_cfg.steps_per_move <= RST_STEPS;
            r_cfg.hold_ticks     <= RST_HOLD;
            r_cfg.trigger_level  <= RST_TRIGGER;
            r_cfg.rearm_level    <= RST_REARM;
            r_cfg.weight_offset  <= RST_OFFSET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_DEBOUNCE: r_cfg.debounce_ticks <= i_wr_data[7:0];
                CFG_PERIOD:   r_cfg.step_period    <= i_wr_data[7:0];
                CFG_STEPS:    r_cfg.steps_per_move <= i_wr_data[15:0];
                CFG_HOLD:     r_cfg.hold_ticks     <= i_wr_data[15:0];
                CFG_TRIGGER:  r_cfg.trigger_level  <= $signed(i_wr_data[WEIGHT_W-1:0]);
                CFG_REARM:    r_cfg.rearm_level    <= $signed(i_wr_data[WEIGHT_W-1:0]);
                CFG_OFFSET:   r_cfg.weight_offset  <= $signed(i_wr_data[OFFSET_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ===== rtl/core/sohrc_debounce.sv =====
`default_nettype none
module sohrc_debounce (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_raw,
    input  wire logic [7:0] i_debounce_ticks,
    output logic            o_stable,
    output logic            o_press
);
    logic       r_stable;
    logic       r_last_raw;
    logic [7:0] r_age;
    logic       n_stable;
    logic       n_last_raw;
    logic [7:0] n_age;
    logic       w_follow;

    // Age of the current raw level, saturating
    always_comb begin
        n_last_raw = r_last_raw;
        n_age      = r_age;
        if (i_raw != r_last_raw) begin
            n_last_raw = i_raw;
            n_age      = '0;
        end else if (r_age != 8'hFF) begin
            n_age = r_age + 8'd1;
        end
    end

    // Stable level follows once the raw level is old enough
    assign w_follow = (i_raw != r_stable) && (n_age >= i_debounce_ticks);
    assign n_stable = w_follow ? i_raw : r_stable;
    assign o_press  = i_en && w_follow && i_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b0;
            r_last_raw <= 1'b0;
            r_age      <= '0;
        end else if (i_en) begin
            r_stable   <= n_stable;
            r_last_raw <= n_last_raw;
            r_age      <= n_age;
        end
    end

    assign o_stable = r_stable;
endmodule
`default_nettype wire

// ===== rtl/core/sohrc_weight.sv =====
`default_nettype none
module sohrc_weight (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_sample_valid,
    input  wire logic signed [sohrc_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                                  i_can_start,
    input  wire logic signed [sohrc_pkg::WEIGHT_W-1:0] i_trigger_level,
    input  wire logic signed [sohrc_pkg::WEIGHT_W-1:0] i_rearm_level,
    output logic                                       o_start,
    output logic signed [sohrc_pkg::WEIGHT_W-1:0]      o_weight,
    output logic                                       o_armed
);
    import sohrc_pkg::*;

    logic signed [WEIGHT_W-1:0] r_weight;
    logic                       r_armed;
    logic                       w_armed_mid;
    logic                       w_fire;

    // Hysteresis: rearm at low weight, fire at high weight if idle
    assign w_armed_mid = r_armed || (i_weight <= i_rearm_level);
    assign w_fire      = i_sample_valid && w_armed_mid && (i_weight >= i_trigger_level)
                         && i_can_start;
    assign o_start     = i_en && w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
            r_armed  <= 1'b1;
        end else if (i_en && i_sample_valid) begin
            r_weight <= i_weight;
            r_armed  <= w_armed_mid && !w_fire;
        end
    end

    assign o_weight = r_weight;
    assign o_armed  = r_armed;
endmodule
`default_nettype wire

// ===== rtl/core/sohrc_motor.sv =====
`default_nettype none
module sohrc_motor (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_start,
    input  wire sohrc_pkg::t_cfg i_cfg,
    output logic [3:0]           o_coils,
    output sohrc_pkg::t_mode     o_mode,
    output logic [7:0]           o_cycles
);
    import sohrc_pkg::*;

    t_mode       r_mode,   n_mode;
    logic [1:0]  r_phase,  n_phase;
    logic [3:0]  r_coils,  n_coils;
    logic [15:0] r_steps,  n_steps;
    logic [7:0]  r_wait,   n_wait;
    logic [15:0] r_hold,   n_hold;
    logic [7:0]  r_cycles, n_cycles;

    // One tick of the sequencer: optional start, then service
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_coils  = r_coils;
        n_steps  = r_steps;
        n_wait   = r_wait;
        n_hold   = r_hold;
        n_cycles = r_cycles;

        if (i_start && r_mode == MODE_IDLE) begin
            n_mode   = MODE_OUT;
            n_steps  = i_cfg.steps_per_move;
            n_wait   = '0;
            n_cycles = r_cycles + 8'd1;
        end

        case (n_mode)
            MODE_HOLD: begin
                if (n_hold != '0) begin
                    n_hold = n_hold - 16'd1;
                end
                if (n_hold == '0) begin
                    n_mode  = MODE_HOME;
                    n_steps = i_cfg.steps_per_move;
                    n_wait  = '0;
                end
            end
            MODE_OUT, MODE_HOME: begin
                if (n_wait != '0) begin
                    n_wait = n_wait - 8'd1;
                end
                if (n_wait == '0) begin
                    n_wait  = i_cfg.step_period;
                    n_phase = (n_mode == MODE_OUT) ? n_phase + 2'd1 : n_phase - 2'd1;
                    n_coils = 4'b0001 << n_phase;
                    if (n_steps != '0) begin
                        n_steps = n_steps - 16'd1;
                    end
                    if (n_steps == '0) begin
                        if (n_mode == MODE_OUT) begin
                            n_mode = MODE_HOLD;
                            n_hold = i_cfg.hold_ticks;
                        end else begin
                            n_mode  = MODE_IDLE;
                            n_coils = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_phase  <= '0;
            r_coils  <= '0;
            r_steps  <= '0;
            r_wait   <= '0;
            r_hold   <= '0;
            r_cycles <= '0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_coils  <= n_coils;
            r_steps  <= n_steps;
            r_wait   <= n_wait;
            r_hold   <= n_hold;
            r_cycles <= n_cycles;
        end
    end

    assign o_coils  = r_coils;
    assign o_mode   = r_mode;
    assign o_cycles = r_cycles;
endmodule
`default_nettype wire

// ===== rtl/core/stepper_out_hold_return_controller.sv =====
// Stepper out-hold-return controller.
// i_in carries one millisecond tick per transaction: raw button level and an
// optional signed load-cell sample. o_out returns one status transaction per
// tick: coil enables, motor state, cycle count, weight, debounced button and
// the weight-trigger armed flag, all taken after that tick's update.
// i_cfg writes one register per transaction (index, data); it is always ready
// and must only be used while no tick is in flight.
// Throughput: one tick per clock while o_out is not stalled. A tick passes an
// input register that also forms the tare-corrected, saturated weight, then the
// state registers, which double as the result register.
// When o_out stalls the state holds and the input register keeps one tick;
// i_in drops ready only while both stages are full.
// Reset (synchronous, active low) restores the register defaults, idles the
// motor with coils off, clears counters and arms the weight trigger.
`default_nettype none
module stepper_out_hold_return_controller #(
    parameter int SAMPLE_BITS = sohrc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sohrc_in_if.sink   i_in,
    sohrc_out_if.source o_out,
    sohrc_cfg_if.sink  i_cfg
);
    import sohrc_pkg::*;

    localparam int DIFF_W = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
    localparam logic signed [DIFF_W-1:0] DIFF_MAX = DIFF_W'(WEIGHT_MAX);
    localparam logic signed [DIFF_W-1:0] DIFF_MIN = DIFF_W'(WEIGHT_MIN);

    t_cfg                       w_cfg;
    logic                       r_s1_valid;
    logic                       r_s1_button;
    logic                       r_s1_sample_valid;
    logic signed [WEIGHT_W-1:0] r_s1_weight;
    logic                       r_out_valid;
    logic                       w_en;
    logic                       w_in_take;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [WEIGHT_W-1:0] w_weight;
    logic                       w_press;
    logic                       w_wt_start;
    logic                       w_stable;
    logic signed [WEIGHT_W-1:0] w_weight_now;
    logic                       w_armed;
    logic [3:0]                 w_coils;
    t_mode                      w_mode;
    logic [7:0]                 w_cycles;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    sohrc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    // Handshake: stage 1 advances when the result slot is free or drained
    assign w_en       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_en;
    assign w_in_take  = i_in.valid && i_in.ready;

    // Tare-corrected weight, saturated to the result range
    always_comb begin
        w_diff = DIFF_W'($signed(i_in.sample_counts)) - DIFF_W'(w_cfg.weight_offset);
        if (w_diff > DIFF_MAX) begin
            w_weight = WEIGHT_MAX;
        end else if (w_diff < DIFF_MIN) begin
            w_weight = WEIGHT_MIN;
        end else begin
            w_weight = w_diff[WEIGHT_W-1:0];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (w_in_take) begin
            r_s1_button       <= i_in.button_raw;
            r_s1_sample_valid <= i_in.sample_valid;
            r_s1_weight       <= w_weight;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    sohrc_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_raw            (r_s1_button),
        .i_debounce_ticks (w_cfg.debounce_ticks),
        .o_stable         (w_stable),
        .o_press          (w_press)
    );

    // A button start this tick makes the block busy for the weight check
    sohrc_weight u_weight (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_sample_valid  (r_s1_sample_valid),
        .i_weight        (r_s1_weight),
        .i_can_start     ((w_mode == MODE_IDLE) && !w_press),
        .i_trigger_level (w_cfg.trigger_level),
        .i_rearm_level   (w_cfg.rearm_level),
        .o_start         (w_wt_start),
        .o_weight        (w_weight_now),
        .o_armed         (w_armed)
    );

    sohrc_motor u_motor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_start  (w_press || w_wt_start),
        .i_cfg    (w_cfg),
        .o_coils  (w_coils),
        .o_mode   (w_mode),
        .o_cycles (w_cycles)
    );

    // Result payload straight from the state registers
    assign o_out.valid         = r_out_valid;
    assign o_out.coil_drive    = w_coils;
    assign o_out.motor_state   = w_mode;
    assign o_out.cycle_total   = w_cycles;
    assign o_out.weight_now    = w_weight_now;
    assign o_out.button_stable = w_stable;
    assign o_out.weight_armed  = w_armed;

    // Coils are off whenever the motor is idle
    a_idle_coils_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mode == MODE_IDLE) |-> (w_coils == 4'd0))
        else $error("coils energized while idle");

    // State never moves without a processed tick
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(w_cycles) && $stable(w_mode) && $stable(w_armed)))
        else $error("state changed without a tick");

    // Leaving idle always counts a new cycle
    a_start_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mode == MODE_IDLE) ##1 (w_mode != MODE_IDLE)
        |-> (w_cycles == 8'($past(w_cycles) + 8'd1)))
        else $error("cycle started without count");

    // Both stages full and stalled: input must not be accepted
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while pipeline full");
endmodule
`default_nettype wire

// ===== sim/stepper_out_hold_return_controller_tb.sv =====
`timescale 1ns / 100ps

module stepper_out_hold_return_controller_tb;
    import sohrc_pkg::*;

    localparam int GAP_MAX         = 17;
    localparam int RANDOM_PHASES   = 12;
    localparam int TICKS_PER_PHASE = 50;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_NS     = 5_000_000;

    // One status transaction as seen on o_out
    typedef struct packed {
        logic [3:0]          coil_drive;
        logic [1:0]          motor_state;
        logic [7:0]          cycle_total;
        logic [WEIGHT_W-1:0] weight_now;
        logic                button_stable;
        logic                weight_armed;
    } t_status;

    // Tracks registers and sequencer state, predicts the status for each tick
    class sequencer_scoreboard;
        logic [7:0]                 debounce_ticks;
        logic [7:0]                 step_period;
        logic [15:0]                steps_per_move;
        logic [15:0]                hold_ticks;
        logic signed [WEIGHT_W-1:0] trigger_level;
        logic signed [WEIGHT_W-1:0] rearm_level;
        logic signed [OFFSET_W-1:0] weight_offset;

        logic                       stable_level;
        logic                       last_raw;
        logic [7:0]                 debounce_age;
        t_mode                      mode;
        logic [1:0]                 phase;
        logic [3:0]                 coils;
        logic [15:0]                steps_left;
        logic [7:0]                 step_wait;
        logic [15:0]                hold_left;
        logic [7:0]                 cycles;
        logic signed [WEIGHT_W-1:0] last_weight;
        logic                       armed;

        t_status                    expected_status_q[$];
        int                         errors;

        function new();
            debounce_ticks = RST_DEBOUNCE;
            step_period    = RST_PERIOD;
            steps_per_move = RST_STEPS;
            hold_ticks     = RST_HOLD;
            trigger_level  = RST_TRIGGER;
            rearm_level    = RST_REARM;
            weight_offset  = RST_OFFSET;
            stable_level   = 1'b0;
            last_raw       = 1'b0;
            debounce_age   = '0;
            mode           = MODE_IDLE;
            phase          = '0;
            coils          = '0;
            steps_left     = '0;
            step_wait      = '0;
            hold_left      = '0;
            cycles         = '0;
            last_weight    = '0;
            armed          = 1'b1;
            errors         = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE: debounce_ticks = data[7:0];
                CFG_PERIOD:   step_period    = data[7:0];
                CFG_STEPS:    steps_per_move = data[15:0];
                CFG_HOLD:     hold_ticks     = data[15:0];
                CFG_TRIGGER:  trigger_level  = data[WEIGHT_W-1:0];
                CFG_REARM:    rearm_level    = data[WEIGHT_W-1:0];
                CFG_OFFSET:   weight_offset  = data[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        // Starts a move only from idle
        function void start_cycle();
            if (mode != MODE_IDLE) return;
            mode       = MODE_OUT;
            steps_left = steps_per_move;
            step_wait  = '0;
            cycles     = cycles + 8'd1;
        endfunction

        // One accepted tick: debounce, weight check, then the stepper
        function void note_tick(input logic raw, input logic fresh,
                                input logic [SAMPLE_BITS_DEF-1:0] counts);
            int      w;
            t_status s;

            if (raw != last_raw) begin
                last_raw     = raw;
                debounce_age = '0;
            end else if (debounce_age < 8'd255) begin
                debounce_age = debounce_age + 8'd1;
            end
            if (raw != stable_level && debounce_age >= debounce_ticks) begin
                stable_level = raw;
                if (raw) start_cycle();
            end

            if (fresh) begin
                w = int'($signed(counts)) - int'(weight_offset);
                last_weight = w[WEIGHT_W-1:0];
                if (w <= int'(rearm_level)) armed = 1'b1;
                if (armed && w >= int'(trigger_level) && mode == MODE_IDLE) begin
                    armed = 1'b0;
                    start_cycle();
                end
            end

            case (mode)
                MODE_IDLE: ;
                MODE_HOLD: begin
                    if (hold_left != 0) hold_left = hold_left - 16'd1;
                    if (hold_left == 0) begin
                        mode       = MODE_HOME;
                        steps_left = steps_per_move;
                        step_wait  = '0;
                    end
                end
                default: begin
                    if (step_wait != 0) step_wait = step_wait - 8'd1;
                    if (step_wait == 0) begin
                        step_wait = step_period;
                        phase     = phase + ((mode == MODE_OUT) ? 2'd1 : 2'd3);
                        coils     = 4'b0001 << phase;
                        if (steps_left != 0) steps_left = steps_left - 16'd1;
                        if (steps_left == 0) begin
                            if (mode == MODE_OUT) begin
                                mode      = MODE_HOLD;
                                hold_left = hold_ticks;
                            end else begin
                                mode  = MODE_IDLE;
                                coils = '0;
                            end
                        end
                    end
                end
            endcase

            s.coil_drive    = coils;
            s.motor_state   = mode;
            s.cycle_total   = cycles;
            s.weight_now    = last_weight;
            s.button_stable = stable_level;
            s.weight_armed  = armed;
            expected_status_q.push_back(s);
        endfunction

        // Compares one status transaction with the oldest prediction
        function void check_status(input t_status got);
            t_status want;

            if (expected_status_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("status transaction with no tick pending: coils %h state %0d",
                             got.coil_drive, got.motor_state);
                return;
            end
            want = expected_status_q.pop_front();
            if (got.coil_drive !== want.coil_drive || got.motor_state !== want.motor_state ||
                got.cycle_total !== want.cycle_total || got.weight_now !== want.weight_now ||
                got.button_stable !== want.button_stable ||
                got.weight_armed !== want.weight_armed) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("status mismatch at %0t: exp coils %h state %0d cycles %0d ",
                             $realtime, want.coil_drive, want.motor_state, want.cycle_total,
                             "weight %0d button %0b armed %0b / got coils %h state %0d ",
                             $signed(want.weight_now), want.button_stable, want.weight_armed,
                             got.coil_drive, got.motor_state,
                             "cycles %0d weight %0d button %0b armed %0b",
                             got.cycle_total, $signed(got.weight_now), got.button_stable,
                             got.weight_armed);
            end
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;

    sohrc_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) tick_if ();
    sohrc_out_if                                 status_if ();
    sohrc_cfg_if                                 cfg_if ();

    stepper_out_hold_return_controller #(
        .SAMPLE_BITS(SAMPLE_BITS_DEF)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (status_if),
        .i_cfg   (cfg_if)
    );

    sequencer_scoreboard status_sb;
    bit                  source_steady;
    bit                  sink_steady;
    logic                btn_level;
    int                  btn_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(WATCHDOG_NS);
        $display("stepper_out_hold_return_controller_tb: done, errors");
        $finish;
    end

    // Drops tick valid and waits until every status transaction is back
    task automatic wait_drained();
        tick_if.valid = 1'b0;
        while (status_sb.pending() != 0) @(negedge i_clk);
    endtask

    // One register write transaction, only with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        status_sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // One tick transaction; valid stays up for a back-to-back successor
    task automatic send_tick(input logic raw, input logic fresh,
                             input logic [SAMPLE_BITS_DEF-1:0] counts);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            tick_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_if.button_raw    = raw;
        tick_if.sample_valid  = fresh;
        tick_if.sample_counts = counts;
        tick_if.valid         = 1'b1;
        do @(posedge i_clk); while (!tick_if.ready);
        status_sb.note_tick(raw, fresh, counts);
        @(negedge i_clk);
    endtask

    // Press/release runs with bounce, weights mostly near the two thresholds
    task automatic run_random_ticks(input int count);
        int                         pick;
        int                         level;
        logic                       raw;
        logic                       fresh;
        logic [SAMPLE_BITS_DEF-1:0] counts;
        for (int n = 0; n < count; n++) begin
            if (btn_left == 0) begin
                btn_level = ~btn_level;
                btn_left  = $urandom_range(0, int'(status_sb.debounce_ticks) * 3 / 2 + 3);
            end else begin
                btn_left--;
            end
            raw = btn_level;
            if ($urandom_range(0, 11) == 0) raw = ~raw;

            fresh = ($urandom_range(0, 2) == 0);
            pick  = $urandom_range(0, 9);
            if (pick < 4)
                level = int'(status_sb.trigger_level) + int'($urandom_range(0, 8)) - 4;
            else if (pick < 7)
                level = int'(status_sb.rearm_level) + int'($urandom_range(0, 8)) - 4;
            else
                level = int'(status_sb.rearm_level) + int'($urandom_range(0, 200)) - 100;
            counts = SAMPLE_BITS_DEF'(level + int'(status_sb.weight_offset));
            if (pick == 9) counts = SAMPLE_BITS_DEF'($urandom());
            send_tick(raw, fresh, counts);
        end
    endtask

    // Status sink with random stalls
    initial begin
        t_status got;
        int      stall;
        status_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
                status_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            status_if.ready = 1'b1;
            do @(posedge i_clk); while (!status_if.valid);
            got.coil_drive    = status_if.coil_drive;
            got.motor_state   = status_if.motor_state;
            got.cycle_total   = status_if.cycle_total;
            got.weight_now    = status_if.weight_now;
            got.button_stable = status_if.button_stable;
            got.weight_armed  = status_if.weight_armed;
            status_sb.check_status(got);
            @(negedge i_clk);
        end
    end

    // Stimulus
    initial begin
        logic [7:0]  deb;
        logic [7:0]  per;
        logic [15:0] stp;
        logic [15:0] hld;
        int          trig;
        int          rearm;
        int          off;

        status_sb             = new();
        source_steady         = 1'b0;
        sink_steady           = 1'b0;
        btn_level             = 1'b0;
        btn_left              = 0;
        tick_if.valid         = 1'b0;
        tick_if.button_raw    = 1'b0;
        tick_if.sample_valid  = 1'b0;
        tick_if.sample_counts = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = CFG_DEBOUNCE;
        cfg_if.data           = '0;
        i_rst_n               = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset thresholds: just under trigger, just over rearm, short press
        send_tick(1'b0, 1'b1, 24'd499);
        send_tick(1'b1, 1'b1, 24'd451);
        send_tick(1'b1, 1'b0, 24'd0);

        // Zero debounce, period, steps and hold
        write_reg(CFG_DEBOUNCE, '0);
        write_reg(CFG_PERIOD, '0);
        write_reg(CFG_STEPS, '0);
        write_reg(CFG_HOLD, '0);

        // Button and weight in one tick: button wins, arming kept
        send_tick(1'b1, 1'b1, 24'h7FFFFF);
        // Release at once, weight trigger while busy ignored
        send_tick(1'b0, 1'b1, 24'h7FFFFF);
        // Press while moving home ignored
        send_tick(1'b1, 1'b0, 24'h000000);
        // Weight trigger from idle disarms, then hysteresis band, then rearm
        send_tick(1'b1, 1'b1, 24'd600);
        send_tick(1'b0, 1'b1, 24'd480);
        send_tick(1'b0, 1'b1, 24'd450);
        send_tick(1'b0, 1'b1, 24'h800000);
        send_tick(1'b0, 1'b0, 24'h000000);

        // Most negative tare, largest trigger, lowest rearm
        write_reg(CFG_OFFSET, 25'h0800000);
        write_reg(CFG_TRIGGER, 25'h0FFFFFF);
        write_reg(CFG_REARM, 25'h1000000);
        send_tick(1'b0, 1'b1, 24'h7FFFFF);
        send_tick(1'b0, 1'b1, 24'h800000);
        send_tick(1'b0, 1'b0, 24'h000000);
        send_tick(1'b0, 1'b0, 24'h000000);

        // Most positive tare, lowest trigger, then highest rearm
        write_reg(CFG_OFFSET, 25'h07FFFFF);
        write_reg(CFG_TRIGGER, 25'h1000000);
        send_tick(1'b0, 1'b1, 24'h800000);
        write_reg(CFG_REARM, 25'h0FFFFFF);
        send_tick(1'b0, 1'b1, 24'h800000);
        send_tick(1'b0, 1'b1, 24'h000000);

        // Short debounce with a bounce
        write_reg(CFG_DEBOUNCE, 25'd2);
        send_tick(1'b1, 1'b0, 24'h000000);
        send_tick(1'b0, 1'b0, 24'h000000);
        send_tick(1'b1, 1'b0, 24'h000000);
        send_tick(1'b1, 1'b0, 24'h000000);
        send_tick(1'b1, 1'b0, 24'h000000);

        // Sender holds off until all status is back
        wait_drained();

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            deb   = 8'($urandom_range(1, 6));
            per   = 8'($urandom_range(1, 4));
            stp   = 16'($urandom_range(1, 6));
            hld   = 16'($urandom_range(1, 20));
            case ($urandom_range(0, 5))
                0: deb = '0;
                1: per = '0;
                2: stp = '0;
                3: hld = '0;
                default: ;
            endcase
            trig  = int'($urandom_range(0, 2000)) - 1000;
            rearm = trig - int'($urandom_range(0, 100));
            off   = int'($urandom_range(0, 2000)) - 1000;
            if ($urandom_range(0, 3) == 0) begin
                trig  = $urandom();
                rearm = $urandom();
                off   = $urandom();
            end
            // Reset debounce and step rate once
            if (k == 3) begin
                deb = RST_DEBOUNCE;
                per = RST_PERIOD;
            end
            // Largest settings last: the move they start outlasts the run
            if (k == RANDOM_PHASES - 1) begin
                deb = 8'hFF;
                per = 8'hFF;
                stp = 16'hFFFF;
                hld = 16'hFFFF;
            end
            write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
            write_reg(CFG_PERIOD, CFG_DATA_W'(per));
            write_reg(CFG_STEPS, CFG_DATA_W'(stp));
            write_reg(CFG_HOLD, CFG_DATA_W'(hld));
            write_reg(CFG_TRIGGER, CFG_DATA_W'(trig));
            write_reg(CFG_REARM, CFG_DATA_W'(rearm));
            write_reg(CFG_OFFSET, CFG_DATA_W'(off));
            run_random_ticks(TICKS_PER_PHASE);
        end

        // Drain, settle, report
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (status_sb.errors == 0 && status_sb.pending() == 0) begin
            $display("stepper_out_hold_return_controller_tb: done, clean");
        end else begin
            $display("stepper_out_hold_return_controller_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sohrc_pkg.sv
rtl/core/sohrc_in_if.sv
rtl/core/sohrc_out_if.sv
rtl/core/sohrc_cfg_if.sv
rtl/core/sohrc_cfg_regs.sv
rtl/core/sohrc_debounce.sv
rtl/core/sohrc_weight.sv
rtl/core/sohrc_motor.sv
rtl/core/stepper_out_hold_return_controller.sv
sim/stepper_out_hold_return_controller_tb.sv
